### rtl/core/cpe_pkg.sv
// shared types, widths and constants of the color palette extractor
package cpe_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

    localparam int COLOR_W        = 8;
    localparam int PIXEL_W        = 3 * COLOR_W;
    localparam int POS_W          = 12;
    localparam int TOL_W          = 18;
    localparam int MAXC_W         = 7;
    localparam int SHIFT_W        = 3;
    localparam int SQ_W           = 2 * COLOR_W;
    localparam int ENTRY_INDEX_W  = 6;
    localparam int USED_ENTRIES_W = 7;
    localparam int LIM_W          = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 18;

    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(900);
    localparam logic [MAXC_W-1:0]  MAXC_RESET  = MAXC_W'(50);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(2);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOLERANCE_SQ = 2'd0,
        CFG_MAX_COLORS   = 2'd1,
        CFG_SAMPLE_SHIFT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [POS_W-1:0]   x_pos;
        logic [POS_W-1:0]   y_pos;
        logic               frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic                      sampled;
        logic                      matched;
        logic                      added;
        logic                      dropped;
        logic [ENTRY_INDEX_W-1:0]  entry_index;
        logic [USED_ENTRIES_W-1:0] used_entries;
    } result_t;

endpackage

### rtl/core/cpe_ram.sv
// generic single write port ram with registered read
module cpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/cpe_dist.sv
// squared rgb distance unit with tolerance compare
module cpe_dist (
    input  logic [cpe_pkg::PIXEL_W-1:0] pixel,
    input  logic [cpe_pkg::PIXEL_W-1:0] entry,
    input  logic [cpe_pkg::TOL_W-1:0]   tolerance_sq,
    output logic                        hit
);
    import cpe_pkg::*;

    logic [COLOR_W-1:0] diff_r, diff_g, diff_b;
    logic [SQ_W-1:0]    sq_r, sq_g, sq_b;
    logic [TOL_W-1:0]   dist_sq;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        diff_r  = abs_diff(pixel[PIXEL_W-1 -: COLOR_W], entry[PIXEL_W-1 -: COLOR_W]);
        diff_g  = abs_diff(pixel[2*COLOR_W-1 -: COLOR_W], entry[2*COLOR_W-1 -: COLOR_W]);
        diff_b  = abs_diff(pixel[COLOR_W-1:0], entry[COLOR_W-1:0]);
        sq_r    = SQ_W'(diff_r) * SQ_W'(diff_r);
        sq_g    = SQ_W'(diff_g) * SQ_W'(diff_g);
        sq_b    = SQ_W'(diff_b) * SQ_W'(diff_b);
        dist_sq = TOL_W'(sq_r) + TOL_W'(sq_g) + TOL_W'(sq_b);
        hit     = dist_sq < tolerance_sq;
    end

endmodule

### rtl/core/color_palette_extractor.sv
// top level: palette table, scan sequencer, config registers and result register
//
// One pixel per transaction goes in and one result per transaction comes out.
// The block takes one pixel at a time: an off-grid pixel skips the palette scan and
// goes straight to the output stage, while a sampled pixel is first compared
// against the filled palette entries in order until one matches (all filled entries
// when there is none). The next pixel is taken in the cycle after the result is
// loaded. The scan is paced by the single read port of the palette
// memory feeding one distance unit, one entry per cycle. The result
// register lets the next pixel be accepted while the previous result waits. The
// palette memory needs no clearing pass: only entries below the fill count are read.
// Register writes are taken at any time but belong to idle periods.
module color_palette_extractor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cpe_pkg::pixel_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cpe_pkg::result_t                m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cpe_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PIXEL_W-1:0] pix_reg, pix_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic [TOL_W-1:0]   tolerance_sq_reg;
    logic [MAXC_W-1:0]  max_colors_reg;
    logic [SHIFT_W-1:0] sample_shift_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [PIXEL_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [PIXEL_W-1:0] ram_rdata;
    logic               dist_hit;

    logic [POS_W-1:0]   grid_mask;
    logic               on_grid;
    logic [LIM_W-1:0]   limit;
    logic [CNT_W-1:0]   start_count;

    cpe_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpe_dist u_dist (
        .pixel        (pix_reg),
        .entry        (ram_rdata),
        .tolerance_sq (tolerance_sq_reg),
        .hit          (dist_hit)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_sq_reg <= TOL_RESET;
            max_colors_reg   <= MAXC_RESET;
            sample_shift_reg <= SHIFT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TOLERANCE_SQ: tolerance_sq_reg <= TOL_W'(cfg_data);
                CFG_MAX_COLORS:   max_colors_reg   <= MAXC_W'(cfg_data);
                CFG_SAMPLE_SHIFT: sample_shift_reg <= SHIFT_W'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        grid_mask = ~({POS_W{1'b1}} << sample_shift_reg);
        on_grid   = ((s_data.x_pos & grid_mask) == '0) && ((s_data.y_pos & grid_mask) == '0);
        if (LIM_W'(max_colors_reg) > LIM_W'(TABLE_DEPTH)) begin
            limit = LIM_W'(TABLE_DEPTH);
        end else begin
            limit = LIM_W'(max_colors_reg);
        end
        start_count = s_data.frame_start ? '0 : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        pix_reg      <= pix_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        rd_valid_next = 1'b0;
        count_next    = count_reg;
        pix_next      = pix_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        ram_wdata     = pix_reg;
        ram_raddr     = scan_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pix_next              = {s_data.red, s_data.green, s_data.blue};
                    count_next            = start_count;
                    res_next.sampled      = on_grid;
                    res_next.matched      = 1'b0;
                    res_next.added        = 1'b0;
                    res_next.dropped      = 1'b0;
                    res_next.entry_index  = '0;
                    res_next.used_entries = USED_ENTRIES_W'(start_count);
                    scan_idx_next         = '0;
                    state_next            = on_grid ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (rd_valid_reg && dist_hit) begin
                    res_next.matched     = 1'b1;
                    res_next.entry_index = ENTRY_INDEX_W'(cmp_idx_reg);
                    state_next           = ST_DONE;
                end else if (scan_idx_reg < count_reg) begin
                    rd_valid_next = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end else begin
                    // no match in the filled entries
                    if (LIM_W'(count_reg) < limit) begin
                        ram_we                = 1'b1;
                        count_next            = count_reg + CNT_W'(1);
                        res_next.added        = 1'b1;
                        res_next.entry_index  = ENTRY_INDEX_W'(count_reg);
                        res_next.used_entries = USED_ENTRIES_W'(count_reg + CNT_W'(1));
                    end else begin
                        res_next.dropped = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
